[src/thick_line_rasterizer_defines.svh]
// Assertion macros for the thick line rasterizer.
`ifndef THICK_LINE_RASTERIZER_DEFINES_SVH
`define THICK_LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define TLR_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("thick_line_rasterizer: check failed");
// Checked on every clock edge, reset included.
`define TLR_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("thick_line_rasterizer: check failed");
`else
`define TLR_ASSERT(name, prop, clk, rst_n)
`define TLR_ASSERT_ALWAYS(name, prop, clk)
`endif

`endif

[src/tlr_pkg.sv]
// Shared types and constants for the thick line rasterizer.
package tlr_pkg;

  localparam int TLR_MAX_DIM    = 1024;
  localparam int TLR_COORD_BITS = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_DIM_W  = 11;
  localparam int BRUSH_W    = 8;
  localparam int COLOR_W    = 24;
  localparam int OFF_W      = 20;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR   = 2'd3;

  localparam logic [CFG_DIM_W-1:0] IMAGE_DIM_RESET   = 11'd1024;
  localparam logic [BRUSH_W-1:0]   BRUSH_WIDTH_RESET = 8'd1;

  localparam logic MODE_START = 1'b0;

  typedef enum logic [1:0] {
    CASE_SLOPED = 2'd0,
    CASE_HORIZ  = 2'd1,
    CASE_VERT   = 2'd2,
    CASE_POINT  = 2'd3
  } line_case_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PIX  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_NUM  = 7'b0001000,
    S_PROD = 7'b0010000,
    S_ABS  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_e;

endpackage

[src/thick_line_rasterizer.sv]
// Thick line rasterizer: line walk, shared bit-serial divider, square brush stamp.
// A sloped start runs the divider (S_NUM, S_PROD, S_ABS, S_DIV) for its first row; other
// starts stay in S_IDLE. A step passes S_PIX and S_MUL into the output register; the last
// pixel of a sloped position reruns the divider for the next row (one quotient bit per cycle).
// Items are taken only in S_IDLE with no stalled output; the divider bounds position changes.
// Reset (async, active low): idle, no line, registers 1024 x 1024, brush 1, color 0.
`include "thick_line_rasterizer_defines.svh"

module thick_line_rasterizer #(
  parameter int MAX_DIM    = tlr_pkg::TLR_MAX_DIM,
  parameter int COORD_BITS = tlr_pkg::TLR_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [COORD_BITS-1:0]        row_start_i,
  input  logic signed [COORD_BITS-1:0]        col_start_i,
  input  logic signed [COORD_BITS-1:0]        row_end_i,
  input  logic signed [COORD_BITS-1:0]        col_end_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                write_enable_o,
  output logic [tlr_pkg::OFF_W-1:0]           pixel_offset_o,
  output logic [tlr_pkg::COLOR_W-1:0]         pixel_color_o,
  output logic                                line_done_o
);
  import tlr_pkg::*;

  // Coordinate widths: DW holds differences and the computed coordinate,
  // PW the product numerator, PRW a stamp pixel position.
  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int PRW   = DW + 1;
  localparam int CMPW  = (PRW > CFG_DIM_W + 1) ? PRW : CFG_DIM_W + 1;
  localparam int CNT_W = $clog2(PW + 1);

  state_e state_q, state_d;

  // configuration registers
  logic [CFG_DIM_W-1:0] img_w_q, img_h_q;
  logic [BRUSH_W-1:0]   brush_q;
  logic [COLOR_W-1:0]   color_q;

  // line state
  logic                 busy_q;
  line_case_e           case_q;
  logic signed [CW-1:0] step_q, limit_q, r0_q, c0_q;
  logic signed [DW-1:0] dr_q, dc_q, other_q;
  logic [BRUSH_W-1:0]   srow_q, scol_q;

  // pixel stage
  logic signed [PRW-1:0] prow_q, pcol_q;
  logic                  pix_we_q;

  // shared divider
  logic signed [DW-1:0] jd_q;
  logic signed [PW-1:0] prod_q;
  logic [PW-1:0]        dvd_q;
  logic [DW-1:0]        dvs_q;
  logic [DW-1:0]        rem_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;

  // output register
  logic                 out_valid_q, we_q, done_q;
  logic [OFF_W-1:0]     off_q;
  logic [COLOR_W-1:0]   pcolor_q;

  logic in_xfer;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------- start decode ----------------
  logic       col_ne, row_ne;
  line_case_e start_case;
  logic signed [CW-1:0] start_step, start_limit;
  logic signed [DW-1:0] start_other;

  always_comb begin
    col_ne = (col_start_i != col_end_i);
    row_ne = (row_start_i != row_end_i);
    if (col_ne) begin
      start_case  = row_ne ? CASE_SLOPED : CASE_HORIZ;
      start_step  = (col_start_i < col_end_i) ? col_start_i : col_end_i;
      start_limit = (col_start_i < col_end_i) ? col_end_i : col_start_i;
      start_other = DW'(row_start_i);
    end else if (row_ne) begin
      start_case  = CASE_VERT;
      start_step  = (row_start_i < row_end_i) ? row_start_i : row_end_i;
      start_limit = (row_start_i < row_end_i) ? row_end_i : row_start_i;
      start_other = DW'(col_start_i);
    end else begin
      start_case  = CASE_POINT;
      start_step  = row_start_i;
      start_limit = row_start_i;
      start_other = DW'(col_start_i);
    end
  end

  // ---------------- stamp pixel position and clip ----------------
  logic [CFG_DIM_W-1:0]  iw_c, ih_c;
  logic signed [DW-1:0]  crow, ccol;
  logic signed [PRW-1:0] half_s, prow_c, pcol_c;
  logic                  pix_in;

  always_comb begin
    iw_c = (32'(img_w_q) > MAX_DIM) ? CFG_DIM_W'(MAX_DIM) : img_w_q;
    ih_c = (32'(img_h_q) > MAX_DIM) ? CFG_DIM_W'(MAX_DIM) : img_h_q;
    if (case_q == CASE_SLOPED || case_q == CASE_HORIZ) begin
      crow = other_q;
      ccol = DW'(step_q);
    end else begin
      crow = DW'(step_q);
      ccol = other_q;
    end
    half_s = $signed(PRW'({1'b0, brush_q[BRUSH_W-1:1]}));
    prow_c = PRW'(crow) - half_s + $signed(PRW'({1'b0, srow_q}));
    pcol_c = PRW'(ccol) - half_s + $signed(PRW'({1'b0, scol_q}));
    pix_in = (brush_q != '0) &&
             (prow_c >= 0) && (pcol_c >= 0) &&
             (CMPW'(prow_c) < $signed(CMPW'({1'b0, ih_c}))) &&
             (CMPW'(pcol_c) < $signed(CMPW'({1'b0, iw_c})));
  end

  // ---------------- offset, stamp advance ----------------
  logic [CFG_DIM_W-1:0]   prow_u, pcol_u;
  logic [2*CFG_DIM_W-1:0] off_mul;
  logic [OFF_W-1:0]       off_c;
  logic [BRUSH_W:0]       srow_n, scol_n;
  logic                   row_end_c, col_end_c, last_pix, line_end;

  always_comb begin
    prow_u    = CFG_DIM_W'(prow_q);
    pcol_u    = CFG_DIM_W'(pcol_q);
    off_mul   = (2*CFG_DIM_W)'(prow_u) * (2*CFG_DIM_W)'(iw_c);
    off_c     = pix_we_q ? OFF_W'(off_mul + (2*CFG_DIM_W)'(pcol_u)) : '0;
    srow_n    = {1'b0, srow_q} + 1'b1;
    scol_n    = {1'b0, scol_q} + 1'b1;
    row_end_c = (srow_n >= {1'b0, brush_q});
    col_end_c = (scol_n >= {1'b0, brush_q});
    // zero brush: every position is a single unwritten pixel
    last_pix  = (brush_q == '0) || (row_end_c && col_end_c);
    line_end  = last_pix && (step_q >= limit_q);
  end

  // ---------------- divider step and correction ----------------
  logic [DW:0]          rem_sh;
  logic                 q_bit;
  logic signed [DW-1:0] q_mag, q_sgn;

  always_comb begin
    rem_sh = {rem_q, dvd_q[PW-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_q});
    q_mag  = $signed(dvd_q[DW-1:0]);
    q_sgn  = neg_q ? -q_mag : q_mag;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_START) begin
            state_d = (start_case == CASE_SLOPED) ? S_NUM : S_IDLE;
          end else begin
            state_d = busy_q ? S_PIX : S_IDLE;
          end
        end
      end
      S_PIX:  state_d = S_MUL;
      S_MUL:  state_d = (last_pix && !line_end && case_q == CASE_SLOPED) ? S_NUM : S_IDLE;
      S_NUM:  state_d = S_PROD;
      S_PROD: state_d = S_ABS;
      S_ABS:  state_d = S_DIV;
      // one quotient bit per cycle; once cnt_q reaches PW, sign and start row are applied instead
      S_DIV:  state_d = (cnt_q == CNT_W'(PW)) ? S_IDLE : S_DIV;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMAGE_DIM_RESET;
      img_h_q <= IMAGE_DIM_RESET;
      brush_q <= BRUSH_WIDTH_RESET;
      color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[CFG_DIM_W-1:0];
        REG_BRUSH_WIDTH:  brush_q <= cfg_data_i[BRUSH_W-1:0];
        REG_DRAW_COLOR:   color_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // line control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      case_q <= CASE_SLOPED;
      step_q <= '0;
      limit_q <= '0;
      srow_q <= '0;
      scol_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (state_q == S_IDLE && in_xfer && mode_i == MODE_START) begin
        busy_q  <= 1'b1;
        case_q  <= start_case;
        step_q  <= start_step;
        limit_q <= start_limit;
        srow_q  <= '0;
        scol_q  <= '0;
      end
      if (state_q == S_MUL) begin
        if (brush_q != '0) begin
          if (col_end_c) begin
            scol_q <= '0;
            srow_q <= last_pix ? '0 : srow_n[BRUSH_W-1:0];
          end else begin
            scol_q <= scol_n[BRUSH_W-1:0];
          end
        end
        if (line_end) begin
          busy_q <= 1'b0;
        end else if (last_pix) begin
          step_q <= step_q + 1'b1;
        end
      end
      if (state_q == S_ABS) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer && mode_i == MODE_START) begin
      r0_q    <= row_start_i;
      c0_q    <= col_start_i;
      dr_q    <= DW'(row_end_i) - DW'(row_start_i);
      dc_q    <= DW'(col_end_i) - DW'(col_start_i);
      other_q <= start_other;
    end
    if (state_q == S_PIX) begin
      prow_q   <= prow_c;
      pcol_q   <= pcol_c;
      pix_we_q <= pix_in;
    end
    if (state_q == S_NUM) begin
      jd_q <= DW'(step_q) - DW'(c0_q);
    end
    if (state_q == S_PROD) begin
      prod_q <= PW'(jd_q) * PW'(dr_q);
    end
    if (state_q == S_ABS) begin
      neg_q <= prod_q[PW-1] ^ dc_q[DW-1];
      dvd_q <= prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
      dvs_q <= dc_q[DW-1] ? DW'(-dc_q) : DW'(dc_q);
      rem_q <= '0;
    end
    if (state_q == S_DIV) begin
      if (cnt_q == CNT_W'(PW)) begin
        // truncating quotient, signed, plus the start row
        other_q <= q_sgn + DW'(r0_q);
      end else begin
        rem_q <= q_bit ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
        dvd_q <= {dvd_q[PW-2:0], q_bit};
      end
    end
  end

  // output register: loaded once per step, held until the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_MUL) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      we_q     <= pix_we_q;
      off_q    <= off_c;
      pcolor_q <= color_q;
      done_q   <= line_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign pixel_offset_o = off_q;
  assign pixel_color_o  = pcolor_q;
  assign line_done_o    = done_q;

  // ---------------- checks ----------------
  // the output register is never overwritten while a result is pending
  `TLR_ASSERT(a_out_free, (state_q == S_MUL) |-> (!out_valid_q || !out_stall_i), clk_i, rst_ni)
  // the divider never runs past its last quotient bit
  `TLR_ASSERT_ALWAYS(a_div_cnt, (state_q == S_DIV) |-> (cnt_q <= CNT_W'(PW)), clk_i)
  // a finished line leaves the walker idle
  `TLR_ASSERT(a_done_idle, ($rose(out_valid_q) && done_q) |-> !busy_q, clk_i, rst_ni)
  // division only happens for a live sloped line
  `TLR_ASSERT(a_div_sloped, (state_q == S_DIV) |-> (busy_q && case_q == CASE_SLOPED), clk_i, rst_ni)

endmodule

[test/thick_line_rasterizer_test.sv]
// Self-checking testbench for thick_line_rasterizer: directed table, then random line bursts.
`timescale 1ns / 1ps

module thick_line_rasterizer_test;
  import tlr_pkg::*;

  localparam int   CB            = TLR_COORD_BITS;
  localparam logic MODE_STEP     = ~MODE_START;
  localparam int   SETTLE_CYCLES = 64;   // > start/step latency incl. one divider pass
  localparam int   PHASE_ITEMS   = 200;
  localparam int   LAST_PHASE    = 7;
  localparam int   NO_CAP        = 32'h7fff_ffff;
  localparam int   MAX_REPORTS   = 200;

  typedef struct packed {
    logic               we;
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] color;
    logic               done;
  } pixel_t;

  // One row of the directed table: either a register write or an item transfer.
  typedef struct packed {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  m;
    logic [CB-1:0]         rs, cs, re, ce;
    bit                    typed;    // want holds a hand-written expectation
    pixel_t                want;
  } plan_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i      = MODE_START;
  logic signed [CB-1:0]  row_start_i = '0;
  logic signed [CB-1:0]  col_start_i = '0;
  logic signed [CB-1:0]  row_end_i   = '0;
  logic signed [CB-1:0]  col_end_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  write_enable_o;
  logic [OFF_W-1:0]      pixel_offset_o;
  logic [COLOR_W-1:0]    pixel_color_o;
  logic                  line_done_o;

  thick_line_rasterizer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .row_start_i,
    .col_start_i,
    .row_end_i,
    .col_end_i,
    .out_valid_o,
    .out_stall_i,
    .write_enable_o,
    .pixel_offset_o,
    .pixel_color_o,
    .line_done_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow registers, reset values.
  logic [CFG_DIM_W-1:0] sh_width  = IMAGE_DIM_RESET;
  logic [CFG_DIM_W-1:0] sh_height = IMAGE_DIM_RESET;
  logic [BRUSH_W-1:0]   sh_brush  = BRUSH_WIDTH_RESET;
  logic [COLOR_W-1:0]   sh_color  = '0;

  // Line walk state of the predictor.
  bit         line_busy;
  int         walk_pos, walk_last;
  line_case_e line_shape = CASE_SLOPED;
  int         ep_r0, ep_c0, ep_r1, ep_c1;
  int         stamp_r, stamp_c;
  int         side_coord;   // row on a column walk, column on a row walk

  pixel_t expected_pixels[$];
  int     errors;
  int     live_items;       // transfers the block acts on (idle steps excluded)
  int     gap_pct, stall_pct, stall_left;

  task automatic flag(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  function automatic logic signed [CB-1:0] to_coord(input int v);
    return v[CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[CB-1:0];
  endfunction

  // Other coordinate of the walk at step j; division truncates toward zero.
  function automatic int line_coord_at(input int j);
    case (line_shape)
      CASE_SLOPED: return (j - ep_c0) * (ep_r1 - ep_r0) / (ep_c1 - ep_c0) + ep_r0;
      CASE_HORIZ:  return ep_r0;
      default:     return ep_c0;
    endcase
  endfunction

  function automatic void begin_line(input logic signed [CB-1:0] rs, cs, re, ce);
    ep_r0 = rs;
    ep_c0 = cs;
    ep_r1 = re;
    ep_c1 = ce;
    if (ep_c0 != ep_c1) begin
      line_shape = (ep_r0 != ep_r1) ? CASE_SLOPED : CASE_HORIZ;
      walk_pos   = (ep_c0 < ep_c1) ? ep_c0 : ep_c1;
      walk_last  = (ep_c0 < ep_c1) ? ep_c1 : ep_c0;
    end else if (ep_r0 != ep_r1) begin
      line_shape = CASE_VERT;
      walk_pos   = (ep_r0 < ep_r1) ? ep_r0 : ep_r1;
      walk_last  = (ep_r0 < ep_r1) ? ep_r1 : ep_r0;
    end else begin
      line_shape = CASE_POINT;
      walk_pos   = ep_r0;
      walk_last  = ep_r0;
    end
    side_coord = line_coord_at(walk_pos);
    stamp_r    = 0;
    stamp_c    = 0;
    line_busy  = 1'b1;
  endfunction

  // Pixel caused by one step; returns 0 when no line is active.
  function automatic bit next_pixel(output pixel_t px);
    int  crow, ccol, w, iw, ih, half, prow, pcol, lin;
    bit  last;
    px = '0;
    if (!line_busy) return 1'b0;
    if (line_shape == CASE_SLOPED || line_shape == CASE_HORIZ) begin
      crow = side_coord;
      ccol = walk_pos;
    end else begin
      crow = walk_pos;
      ccol = side_coord;
    end
    w  = sh_brush;
    iw = (sh_width  > TLR_MAX_DIM) ? TLR_MAX_DIM : sh_width;
    ih = (sh_height > TLR_MAX_DIM) ? TLR_MAX_DIM : sh_height;
    if (w == 0) begin
      last = 1'b1;    // empty brush: one unwritten pixel per position
    end else begin
      half = w / 2;
      prow = crow - half + stamp_r;
      pcol = ccol - half + stamp_c;
      if (prow >= 0 && pcol >= 0 && prow < ih && pcol < iw) begin
        lin       = prow * iw + pcol;
        px.we     = 1'b1;
        px.offset = lin[OFF_W-1:0];
      end
      last = (stamp_r + 1 >= w) && (stamp_c + 1 >= w);
      if (stamp_c + 1 >= w) begin
        stamp_c = 0;
        stamp_r = last ? 0 : stamp_r + 1;
      end else begin
        stamp_c++;
      end
    end
    if (last) begin
      if (walk_pos >= walk_last) begin
        px.done   = 1'b1;
        line_busy = 1'b0;
      end else begin
        walk_pos++;
        side_coord = line_coord_at(walk_pos);
      end
    end
    px.color = sh_color;
    return 1'b1;
  endfunction

  // Register write at the next edge; upper data bits beyond the register carry noise.
  // The caller lowers cfg_we_i after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [31:0]           r;
    logic [CFG_DATA_W-1:0] data;
    r    = $urandom;
    data = r[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: data[CFG_DIM_W-1:0] = val[CFG_DIM_W-1:0];
      REG_BRUSH_WIDTH:                   data[BRUSH_W-1:0]   = val[BRUSH_W-1:0];
      default:                           data                = val[COLOR_W-1:0];
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:  sh_width  = data[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: sh_height = data[CFG_DIM_W-1:0];
      REG_BRUSH_WIDTH:  sh_brush  = data[BRUSH_W-1:0];
      default:          sh_color  = data[COLOR_W-1:0];
    endcase
  endtask

  // One item transfer, with an optional random gap in front of it.
  task automatic offer(input logic m, input logic signed [CB-1:0] rs, cs, re, ce,
                       input bit typed, input pixel_t want);
    pixel_t got;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    row_start_i <= rs;
    col_start_i <= cs;
    row_end_i   <= re;
    col_end_i   <= ce;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (m == MODE_START) begin
      live_items++;
      begin_line(rs, cs, re, ce);
    end else if (next_pixel(got)) begin
      live_items++;
      expected_pixels.push_back(typed ? want : got);
    end
  endtask

  task automatic step_once();
    offer(MODE_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
  endtask

  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Drained, plus time for a start or divider pass that yields no pixel.
  task automatic settle();
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int signed_delta();
    int d;
    d = $urandom_range(1, 6);
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Short line near the image, then enough steps to finish it (up to step_cap).
  task automatic draw_short_line(input int rows, input int cols, input int step_cap);
    int r0, c0, r1, c1, steps, w;
    r0 = int'($urandom_range(0, rows + 7)) - 4;
    c0 = int'($urandom_range(0, cols + 7)) - 4;
    case ($urandom_range(0, 3))
      0: begin
        r1 = r0 + signed_delta();
        c1 = c0 + signed_delta();
      end
      1: begin
        r1 = r0;
        c1 = c0 + signed_delta();
      end
      2: begin
        r1 = r0 + signed_delta();
        c1 = c0;
      end
      default: begin
        r1 = r0;
        c1 = c0;
      end
    endcase
    offer(MODE_START, to_coord(r0), to_coord(c0), to_coord(r1), to_coord(c1), 1'b0, '0);
    w     = sh_brush;
    steps = (c0 != c1) ? c1 - c0 : r1 - r0;
    if (steps < 0) steps = -steps;
    steps = (steps + 1) * ((w == 0) ? 1 : w * w);
    if (steps > step_cap) steps = step_cap;
    repeat (steps) step_once();
  endtask

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    plan_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t start_row(input int rs, cs, re, ce);
    plan_row_t r;
    r    = '0;
    r.m  = MODE_START;
    r.rs = to_coord(rs);
    r.cs = to_coord(cs);
    r.re = to_coord(re);
    r.ce = to_coord(ce);
    return r;
  endfunction

  function automatic plan_row_t step_row();
    plan_row_t r;
    r    = '0;
    r.m  = MODE_STEP;
    r.rs = rand_coord();
    r.cs = rand_coord();
    r.re = rand_coord();
    r.ce = rand_coord();
    return r;
  endfunction

  function automatic plan_row_t checked_step(input logic we, input logic [OFF_W-1:0] off,
                                             input logic [COLOR_W-1:0] color, input logic done);
    plan_row_t r;
    r             = step_row();
    r.typed       = 1'b1;
    r.want.we     = we;
    r.want.offset = off;
    r.want.color  = color;
    r.want.done   = done;
    return r;
  endfunction

  // Receiver: stall bursts at a rate set by the stimulus.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Every pixel transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        flag($sformatf("pixel with none expected, offset %0d", pixel_offset_o));
      end else begin
        want = expected_pixels.pop_front();
        if (write_enable_o !== want.we)
          flag($sformatf("write_enable %b, expected %b", write_enable_o, want.we));
        if (pixel_offset_o !== want.offset)
          flag($sformatf("pixel_offset %0d, expected %0d", pixel_offset_o, want.offset));
        if (pixel_color_o !== want.color)
          flag($sformatf("pixel_color %h, expected %h", pixel_color_o, want.color));
        if (line_done_o !== want.done)
          flag($sformatf("line_done %b, expected %b", line_done_o, want.done));
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    int        first, roll, rows, cols;
    int        w_val, h_val, b_val;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Reset registers: 1024 x 1024, brush 1, color 0.
    plan.push_back(step_row());                              // step with no line: ignored
    plan.push_back(start_row(0, 0, 0, 0));
    plan.push_back(checked_step(1'b1, '0, '0, 1'b1));
    plan.push_back(reg_row(REG_DRAW_COLOR, 24'hFFFFFF));
    plan.push_back(start_row(1023, 1023, 1023, 1023));       // last pixel of the image
    plan.push_back(checked_step(1'b1, 20'hFFFFF, 24'hFFFFFF, 1'b1));
    plan.push_back(start_row(-2048, -2048, -2048, -2048));   // clipped below zero
    plan.push_back(checked_step(1'b0, '0, 24'hFFFFFF, 1'b1));
    plan.push_back(start_row(2047, 2047, 2047, 2047));       // clipped past the edge
    plan.push_back(checked_step(1'b0, '0, 24'hFFFFFF, 1'b1));
    plan.push_back(start_row(-2048, 2047, 2047, -2048));     // widest slope, abandoned
    plan.push_back(step_row());
    plan.push_back(start_row(5, 2, 5, 0));                   // horizontal, reversed ends
    repeat (3) plan.push_back(step_row());
    plan.push_back(start_row(0, 0, 2, -3));                  // sloped, truncating divide
    repeat (4) plan.push_back(step_row());
    plan.push_back(reg_row(REG_BRUSH_WIDTH, 0));
    plan.push_back(start_row(1, 7, 0, 7));                   // vertical, empty brush
    plan.push_back(checked_step(1'b0, '0, 24'hFFFFFF, 1'b0));
    plan.push_back(checked_step(1'b0, '0, 24'hFFFFFF, 1'b1));
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 2047));          // oversized dims act as 1024
    plan.push_back(reg_row(REG_IMAGE_HEIGHT, 2047));
    plan.push_back(reg_row(REG_BRUSH_WIDTH, 3));
    plan.push_back(reg_row(REG_DRAW_COLOR, 24'h5A3C96));
    plan.push_back(start_row(1, 1, 1, 1));
    repeat (9) plan.push_back(step_row());

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        offer(plan[i].m, plan[i].rs, plan[i].cs, plan[i].re, plan[i].ce,
              plan[i].typed, plan[i].want);
      end
    end

    // Random phases, one register setting each; every line but noise runs to its end,
    // so the block is idle when the registers change. The last phase has a full-size
    // brush, cut-off lines and no idling.
    for (int p = 0; p <= LAST_PHASE; p++) begin
      case (p)
        0: begin w_val = 1024; h_val = 1024; b_val = 1; end
        1: begin w_val = 1;    h_val = 1;    b_val = 2; end
        2: begin w_val = 2047; h_val = 2047; b_val = 0; end
        3: begin
          w_val = $urandom_range(1, 1024);
          h_val = $urandom_range(1, 1024);
          b_val = $urandom_range(1, 5);
        end
        4: begin w_val = 37;   h_val = 20;   b_val = 3; end
        5: begin w_val = 1024; h_val = 1024; b_val = 4; end
        6: begin w_val = 1500; h_val = 480;  b_val = 2; end
        default: begin w_val = 1024; h_val = 1024; b_val = 255; end
      endcase
      settle();
      if (p == LAST_PHASE) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      write_reg(REG_IMAGE_WIDTH, w_val);
      write_reg(REG_IMAGE_HEIGHT, h_val);
      write_reg(REG_BRUSH_WIDTH, b_val);
      write_reg(REG_DRAW_COLOR, $urandom_range(0, 24'hFFFFFF));
      cfg_we_i <= 1'b0;
      rows  = (h_val > TLR_MAX_DIM) ? TLR_MAX_DIM : h_val;
      cols  = (w_val > TLR_MAX_DIM) ? TLR_MAX_DIM : w_val;
      first = live_items;
      while (live_items - first < PHASE_ITEMS) begin
        if (p != LAST_PHASE) begin
          gap_pct   = pick_pct();
          stall_pct = pick_pct();
        end
        roll = $urandom_range(0, 99);
        if (roll < 5 && p != LAST_PHASE) drain_pixels();   // hold off until all pixels are out
        if (roll < 10) begin
          step_once();
        end else if (roll < 22) begin
          // full-range line, cut off by the next start
          offer(MODE_START, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
          repeat ($urandom_range(1, 4)) step_once();
        end
        draw_short_line(rows, cols, (p == LAST_PHASE) ? $urandom_range(1, 80) : NO_CAP);
      end
    end

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: ends a hung run as failed.
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tlr_pkg.sv
src/thick_line_rasterizer.sv
test/thick_line_rasterizer_test.sv
